/* rtl/rsa_pkg.sv */
// Package with the shared types and constants of the RSA key and modexp core.
`timescale 1ns / 1ps
`default_nettype none
package rsa_pkg;
  localparam int unsigned ModulusWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam logic [CfgIdxWidth-1:0] CfgPrimeP = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgPrimeQ = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgPubExp = 2'd2;
  localparam logic ReqEncrypt = 1'b0;
  localparam logic ReqDecrypt = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] message_value;
  } rsa_req_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic        status;
  } rsa_rsp_t;

  // Handshake between the sequencer and the bit-serial modular multiplier.
  typedef struct packed {
    logic                    start;
    logic [ModulusWidth-1:0] a;
    logic [ModulusWidth-1:0] b;
    logic [ModulusWidth-1:0] m;
  } rsa_mul_req_t;

  typedef struct packed {
    logic                    done;
    logic [ModulusWidth-1:0] prod;
  } rsa_mul_rsp_t;
endpackage
`default_nettype wire

/* rtl/rsa_key_and_modexp_core.sv */
// Top level of the RSA key derivation and modular exponentiation core.
//
// Usage: write prime_p (index 0), prime_q (index 1) and public_exponent
// (index 2) through cfg_we_i/cfg_idx_i/cfg_data_i while the core is idle.
// A request word is taken at a clock edge with start high and busy low.
// Each request recomputes n = p*q and phi = (p-1)(q-1), checks e with a
// Euclid loop and runs the extended Euclid loop for d, then reduces the
// message and walks the exponent. A Euclid step is one division, an
// inverse step a division and a product for the t update, an exponent
// bit a multiply (when the bit is set) and a square. Both modes derive d.
// A key that fails the range check answers in the cycle after start. The
// result word appears on rsp_o with done_o high for exactly one cycle;
// the receiver cannot stall.
// Reset returns the registers to p = 5, q = 11, e = 3 and the core to idle.
`timescale 1ns / 1ps
`default_nettype none
module rsa_key_and_modexp_core
  import rsa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  input  wire logic                    start,
  input  wire rsa_req_t                req_i,
  output logic                         busy,
  output logic                         done_o,
  output rsa_rsp_t                     rsp_o
);
  localparam int unsigned W = ModulusWidth;
  localparam int unsigned BitW = $clog2(W + 1);

  typedef enum logic [12:0] {
    StIdle  = 13'b0000000000001,
    StGcdS  = 13'b0000000000010,
    StGcdW  = 13'b0000000000100,
    StInvS  = 13'b0000000001000,
    StInvW  = 13'b0000000010000,
    StInvM  = 13'b0000000100000,
    StInvT  = 13'b0000001000000,
    StRedS  = 13'b0000010000000,
    StRedW  = 13'b0000100000000,
    StMulS  = 13'b0001000000000,
    StMulW  = 13'b0010000000000,
    StSqrS  = 13'b0100000000000,
    StSqrW  = 13'b1000000000000
  } rsa_state_e;

  rsa_state_e state_q, state_d;
  logic [7:0]  p_q, q_q;
  logic [15:0] e_q;
  logic        req_q;
  logic [W-1:0] msg_q, n_q, phi_q;
  logic [W-1:0] r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  logic [W-1:0] acc_q, acc_d, base_q, base_d, ex_q, ex_d;
  logic [BitW-1:0] bit_q, bit_d;
  logic         done_q, done_d;
  rsa_rsp_t     rsp_q, rsp_d;
  logic [7:0]   pm1, qm1;
  logic [W-1:0] n_c, phi_c;
  logic         div_start, div_done;
  logic [W-1:0] div_num, div_den, div_quo, div_rem;
  rsa_mul_req_t mul_req;
  rsa_mul_rsp_t mul_rsp;
  logic [W-1:0] mul_a, mul_b;
  logic [W-1:0] t_new;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= 8'd5; q_q <= 8'd11; e_q <= 16'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPrimeP: p_q <= cfg_data_i[7:0];
        CfgPrimeQ: q_q <= cfg_data_i[7:0];
        CfgPubExp: e_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Modulus and totient from the configured primes, exact in 16 bits.
  assign pm1 = p_q - 8'd1;
  assign qm1 = q_q - 8'd1;
  assign n_c = {8'd0, p_q} * {8'd0, q_q};
  assign phi_c = {8'd0, pm1} * {8'd0, qm1};

  rsa_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // The multiplier works modulo phi for the inverse and modulo n otherwise.
  assign mul_req.start = ((state_q == StMulS) && (bit_q != '0) && ex_q[0]) ||
                         (state_q == StSqrS) || (state_q == StInvM);
  assign mul_req.a = mul_a;
  assign mul_req.b = mul_b;
  assign mul_req.m = ((state_q == StInvM) || (state_q == StInvT)) ? phi_q : n_q;

  rsa_modmul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));

  // Sequencer: gcd check, inverse, reduction of the message, exponent walk.
  always_comb begin
    state_d = state_q;
    r0_d = r0_q; r1_d = r1_q; t0_d = t0_q; t1_d = t1_q;
    acc_d = acc_q; base_d = base_q; ex_d = ex_q; bit_d = bit_q;
    done_d = 1'b0; rsp_d = rsp_q;
    div_start = 1'b0; div_num = r0_q; div_den = r1_q;
    mul_a = acc_q; mul_b = base_q;
    t_new = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (p_q < 8'd2 || q_q < 8'd2 || e_q < 16'd2 || e_q >= phi_c) begin
            rsp_d.result_value = '0; rsp_d.status = 1'b1; done_d = 1'b1;
          end else begin
            r0_d = phi_c; r1_d = W'(e_q);
            t0_d = '0; t1_d = W'(1);
            state_d = StGcdS;
          end
        end
      end
      StGcdS: begin
        div_start = 1'b1; state_d = StGcdW;
      end
      StGcdW: begin
        if (div_done) begin
          if (div_rem == '0) begin
            if (r1_q != W'(1)) begin
              rsp_d.result_value = '0; rsp_d.status = 1'b1;
              done_d = 1'b1; state_d = StIdle;
            end else begin
              r0_d = phi_q; r1_d = W'(e_q); state_d = StInvS;
            end
          end else begin
            r0_d = r1_q; r1_d = div_rem; state_d = StGcdS;
          end
        end
      end
      StInvS: begin
        if (r1_q == '0) begin
          ex_d = t0_q; state_d = StRedS;
        end else begin
          div_start = 1'b1; state_d = StInvW;
        end
      end
      StInvW: begin
        if (div_done) state_d = StInvM;
      end
      StInvM: begin
        // Start q*t1 mod phi; the quotient is always below phi.
        mul_a = div_quo; mul_b = t1_q; state_d = StInvT;
      end
      StInvT: begin
        mul_a = div_quo; mul_b = t1_q;
        if (mul_rsp.done) begin
          // t stays in [0, phi): t0 - q*t1 taken modulo phi.
          t_new = mul_rsp.prod;
          t_new = (t0_q >= t_new) ? (t0_q - t_new) : (t0_q + phi_q - t_new);
          r0_d = r1_q; r1_d = div_rem;
          t0_d = t1_q; t1_d = t_new;
          state_d = StInvS;
        end
      end
      StRedS: begin
        if (req_q == ReqEncrypt) ex_d = W'(e_q);
        div_num = msg_q; div_den = n_q; div_start = 1'b1;
        state_d = StRedW;
      end
      StRedW: begin
        if (div_done) begin
          base_d = div_rem; acc_d = W'(1); bit_d = BitW'(W);
          state_d = StMulS;
        end
      end
      StMulS: begin
        if (bit_q == '0) begin
          rsp_d.result_value = 16'(acc_q); rsp_d.status = 1'b0;
          done_d = 1'b1; state_d = StIdle;
        end else if (ex_q[0]) begin
          state_d = StMulW;
        end else begin
          state_d = StSqrS;
        end
      end
      StMulW: begin
        if (mul_rsp.done) begin
          acc_d = mul_rsp.prod; state_d = StSqrS;
        end
      end
      StSqrS: begin
        mul_a = base_q; state_d = StSqrW;
      end
      StSqrW: begin
        mul_a = base_q;
        if (mul_rsp.done) begin
          base_d = mul_rsp.prod; ex_d = ex_q >> 1;
          bit_d = bit_q - 1'b1; state_d = StMulS;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; done_q <= 1'b0;
    end else begin
      state_q <= state_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d; r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d;
    acc_q <= acc_d; base_q <= base_d; ex_q <= ex_d; bit_q <= bit_d;
    rsp_q <= rsp_d;
    if (state_q == StIdle && start) begin
      req_q <= req_i.req_type; msg_q <= req_i.message_value;
      n_q <= n_c; phi_q <= phi_c;
    end
  end

  assign busy = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(start || (state_q != StIdle))) else $error("result without request");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status) |-> (rsp_q.result_value == '0)) else $error("error word not zero");
  a_ok_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !rsp_q.status) |-> (rsp_q.result_value < n_q || n_q == W'(1)))
    else $error("result not reduced");
endmodule
`default_nettype wire

/* rtl/rsa_modmul.sv */
// Bit-serial interleaved modular multiplier: one bit of the multiplier per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsa_modmul
  import rsa_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rsa_mul_req_t req_i,
  output rsa_mul_rsp_t      rsp_o
);
  localparam int unsigned W = ModulusWidth;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    a_q, a_d, b_q, b_d, m_q, m_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W+1:0]    dbl, add, r1;

  // One step: acc = 2*acc + bit*a, reduced with two conditional subtracts.
  always_comb begin
    acc_d = acc_q; a_d = a_q; b_d = b_q; m_d = m_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    dbl = {1'b0, acc_q, 1'b0};
    if (dbl >= {2'b00, m_q}) dbl = dbl - {2'b00, m_q};
    add = dbl + (b_q[W-1] ? {2'b00, a_q} : '0);
    r1 = add;
    if (r1 >= {2'b00, m_q}) r1 = r1 - {2'b00, m_q};
    if (!busy_q && req_i.start) begin
      acc_d = '0; a_d = req_i.a; b_d = req_i.b; m_d = req_i.m;
      cnt_d = CntW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = r1[W-1:0];
      b_d = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d; m_q <= m_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  // The accumulator stays reduced below the modulus.
  a_acc_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (acc_q < m_q)) else $error("modmul result not reduced");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("modmul done without work");
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("modmul done while busy");
endmodule
`default_nettype wire

/* rtl/rsa_divider.sv */
// Restoring divider, one quotient bit per cycle, for gcd, inverse and message reduction steps.
`timescale 1ns / 1ps
`default_nettype none
module rsa_divider
  import rsa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [ModulusWidth-1:0] num_i,
  input  wire logic [ModulusWidth-1:0] den_i,
  output logic                         done_o,
  output logic [ModulusWidth-1:0]      quo_o,
  output logic [ModulusWidth-1:0]      rem_o
);
  localparam int unsigned W = ModulusWidth;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      trial;

  // Shift one numerator bit into the remainder and try the subtract.
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[W-1]};
    if (!busy_q && start_i) begin
      rem_d = '0; quo_d = num_i; den_d = den_i;
      cnt_d = CntW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      rem_d = trial[W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
  assign rem_o = rem_q;

  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && den_q != '0) |-> (rem_q < den_q)) else $error("div remainder too big");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("div done while busy");
  a_done_past: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("div done without work");
endmodule
`default_nettype wire

/* tb/tb_rsa_key_and_modexp_core.sv */
// Self-checking testbench for the RSA key derivation and modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none
module tb_rsa_key_and_modexp_core;
  import rsa_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    start;
  rsa_req_t                req_i;
  logic                    busy;
  logic                    done_o;
  rsa_rsp_t                rsp_o;

  rsa_key_and_modexp_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  // Queue entries: a request word or a register write.
  typedef struct packed {
    logic                    is_cfg;
    logic [CfgIdxWidth-1:0]  idx;
    logic [CfgDataWidth-1:0] data;
    rsa_req_t                req;
  } pending_t;

  pending_t pending_q[$];
  rsa_rsp_t expected_rsp_q[$];

  // Key material as the testbench models it.
  logic [7:0]  model_p;
  logic [7:0]  model_q;
  logic [15:0] model_e;

  int unsigned idle_pct;
  int unsigned errors;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_cfg;
  bit          drain_hold;
  bit          stim_done;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Least positive inverse of e modulo m by the extended Euclid walk.
  function automatic longint unsigned mod_inverse(longint unsigned e, longint unsigned m);
    longint r0, r1, t0, t1, qt, tmp;
    r0 = longint'(m);
    r1 = longint'(e % m);
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      tmp = r0 - qt * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - qt * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (t0 < 0) t0 += longint'(m);
    return longint'(t0);
  endfunction

  function automatic longint unsigned power_mod(longint unsigned b, longint unsigned x,
                                                longint unsigned n);
    longint unsigned acc;
    acc = 1;
    if (x == 0) return 1;
    b = b % n;
    while (x != 0) begin
      if (x[0]) acc = (acc * b) % n;
      b = (b * b) % n;
      x = x >> 1;
    end
    return acc;
  endfunction

  // Expected response word for one request under the current key.
  function automatic rsa_rsp_t predict_rsp(rsa_req_t rq);
    longint unsigned n, phi, x;
    rsa_rsp_t rs;
    rs.result_value = '0;
    rs.status = 1'b1;
    if (model_p >= 2 && model_q >= 2) begin
      n = longint'(model_p) * longint'(model_q);
      phi = longint'(model_p - 8'd1) * longint'(model_q - 8'd1);
      if (model_e > 1 && model_e < phi && gcd64(model_e, phi) == 1) begin
        x = (rq.req_type == ReqEncrypt) ? longint'(model_e) : mod_inverse(model_e, phi);
        rs.result_value = 16'(power_mod(rq.message_value, x, n));
        rs.status = 1'b0;
      end
    end
    return rs;
  endfunction

  // Driver: takes words from the queue; register writes only when idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      req_i      <= '0;
      cfg_we_i   <= 1'b0;
      cfg_idx_i  <= '0;
      cfg_data_i <= '0;
    end else begin
      cfg_we_i <= 1'b0;
      if (start && !busy) begin
        expected_rsp_q.push_back(predict_rsp(req_i));
        n_accepted++;
      end
      if (start && busy) begin
        // Hold the word until it is taken.
      end else if (!drain_hold && pending_q.size() != 0 &&
                   $urandom_range(99, 0) >= idle_pct) begin
        if (pending_q[0].is_cfg) begin
          start <= 1'b0;
          if (expected_rsp_q.size() == 0 && !(start && !busy) && !busy) begin
            cfg_we_i   <= 1'b1;
            cfg_idx_i  <= pending_q[0].idx;
            cfg_data_i <= pending_q[0].data;
            case (pending_q[0].idx)
              CfgPrimeP: model_p = pending_q[0].data[7:0];
              CfgPrimeQ: model_q = pending_q[0].data[7:0];
              default:   model_e = pending_q[0].data;
            endcase
            n_cfg++;
            void'(pending_q.pop_front());
          end
        end else begin
          start <= 1'b1;
          req_i <= pending_q[0].req;
          void'(pending_q.pop_front());
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h status %b",
                 $time, rsp_o.result_value, rsp_o.status);
        errors++;
      end else begin
        if (rsp_o.result_value !== expected_rsp_q[0].result_value) begin
          $display("%0t: value mismatch: expected %h, actual %h", $time,
                   expected_rsp_q[0].result_value, rsp_o.result_value);
          errors++;
        end
        if (rsp_o.status !== expected_rsp_q[0].status) begin
          $display("%0t: status mismatch: expected %b, actual %b", $time,
                   expected_rsp_q[0].status, rsp_o.status);
          errors++;
        end
        void'(expected_rsp_q.pop_front());
        n_checked++;
      end
    end
  end

  task automatic add_req(logic kind, logic [15:0] msg);
    pending_t w;
    w = '0;
    w.req.req_type = kind;
    w.req.message_value = msg;
    pending_q.push_back(w);
  endtask

  task automatic add_cfg(logic [CfgIdxWidth-1:0] idx, logic [15:0] data);
    pending_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.idx = idx;
    w.data = data;
    pending_q.push_back(w);
  endtask

  task automatic add_key(logic [7:0] p, logic [7:0] q, logic [15:0] e);
    add_cfg(CfgPrimeP, {8'd0, p});
    add_cfg(CfgPrimeQ, {8'd0, q});
    add_cfg(CfgPubExp, e);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || start || busy || expected_rsp_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Stimulus and idling phases.
  initial begin
    int unsigned phase;
    logic [7:0] primes[12];
    primes = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd61, 8'd101, 8'd211, 8'd241,
               8'd251, 8'd255};
    errors = 0;
    n_accepted = 0;
    n_checked = 0;
    n_cfg = 0;
    idle_pct = 0;
    drain_hold = 1'b0;
    stim_done = 1'b0;
    model_p = 8'd5;
    model_q = 8'd11;
    model_e = 16'd3;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset key, message extremes and both request kinds.
    add_req(ReqEncrypt, 16'd0);
    add_req(ReqDecrypt, 16'd1);
    add_req(ReqEncrypt, 16'd54);
    add_req(ReqDecrypt, 16'd55);
    add_req(ReqEncrypt, 16'hffff);
    add_req(ReqDecrypt, 16'hffff);
    // Largest primes, and non-prime values taken as given.
    add_key(8'd251, 8'd241, 16'hffff);
    add_req(ReqEncrypt, 16'hffff);
    add_key(8'd255, 8'd255, 16'd7);
    add_req(ReqEncrypt, 16'hfffe);
    add_req(ReqDecrypt, 16'h1234);
    // Invalid exponents: e = 0, e = 1, e = phi, gcd not one, prime below two.
    add_key(8'd5, 8'd11, 16'd0);
    add_req(ReqEncrypt, 16'd9);
    add_cfg(CfgPubExp, 16'd1);
    add_req(ReqDecrypt, 16'd9);
    add_cfg(CfgPubExp, 16'd40);
    add_req(ReqEncrypt, 16'd9);
    add_cfg(CfgPubExp, 16'd4);
    add_req(ReqEncrypt, 16'd9);
    add_key(8'd0, 8'd11, 16'd3);
    add_req(ReqEncrypt, 16'd9);
    add_key(8'd7, 8'd1, 16'd5);
    add_req(ReqDecrypt, 16'd9);
    // Small modulus, e = phi - 1.
    add_key(8'd2, 8'd7, 16'd5);
    add_req(ReqEncrypt, 16'd13);
    add_req(ReqDecrypt, 16'd13);
    add_key(8'd255, 8'd255, 16'hffff);
    add_req(ReqEncrypt, 16'h5a5a);

    // Random part: idling phases, key changes between groups of requests.
    for (int unsigned g = 0; g < 25; g++) begin
      phase = g % 4;
      if (g == 13) begin
        // Wait until every expected result has come, then hold off the sender.
        wait_drained();
        drain_hold = 1'b1;
        repeat (50) @(posedge clk_i);
        drain_hold = 1'b0;
      end
      wait_drained();
      idle_pct = (phase == 0) ? 0 : (phase == 3) ? 32 : 61;
      repeat (4) @(posedge clk_i);
      if ($urandom_range(9, 0) < 8) begin
        add_key(primes[$urandom_range(11, 0)], primes[$urandom_range(11, 0)],
                $urandom_range(9, 0) < 7 ? 16'($urandom_range(200, 2)) : 16'($urandom));
      end else begin
        add_key(8'($urandom), 8'($urandom), 16'($urandom));
      end
      for (int unsigned k = 0; k < 11; k++)
        add_req(1'($urandom), 16'($urandom));
    end
    wait_drained();
    repeat (1300) @(posedge clk_i);
    stim_done = 1'b1;
    $display("Ran %0d requests with %0d register writes; %0d results checked.",
             n_accepted, n_cfg, n_checked);
    $display("Covered valid and invalid keys, extreme primes and messages, both modes.");
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
